// ----- design/alp_pkg.sv -----
// Shared types, constants and tables for the audio peak limiter.
// No dependencies; imported by alp_ctrl, alp_dp and the top level of the block.
`timescale 1ns / 1ps
package alp_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int SMOOTH_W   = 24;
    localparam int CNT_W      = 4;

    // dB per octave (20*log10(2)) in Q16, and log2(10)/20 in Q24
    localparam logic [18:0]        DB_PER_OCT    = 19'd394566;
    localparam logic signed [22:0] LOG2_10_DIV20 = 23'sd2786635;
    localparam logic [13:0]        KNEE_MIN      = 14'd13;
    localparam logic [16:0]        POW_SEED      = 17'd5206;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd2560;
    localparam logic [15:0]        RELEASE_RST   = 16'd65520;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_KNEE      = 3'd1,
        CFG_MAKEUP    = 3'd2,
        CFG_AUTO      = 3'd3,
        CFG_HARD      = 3'd4,
        CFG_ATTACK    = 3'd5,
        CFG_RELEASE   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] threshold;
        logic [13:0]        knee;
        logic signed [13:0] makeup;
        logic               auto_mk;
        logic               hard;
        logic [15:0]        atk_coeff;
        logic [15:0]        rel_coeff;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NORM, ST_SQUARE, ST_LVL_NEG, ST_LVL_MUL, ST_LVL_RND,
        ST_CRV_SET, ST_CRV_SQ, ST_CRV_DIV, ST_CRV_END,
        ST_SM_PREP, ST_SM_SEL, ST_SM_MUL, ST_SM_ADD, ST_GAIN,
        ST_EXP_MUL, ST_EXP_RND, ST_POW, ST_SCALE, ST_SHIFT, ST_SAT, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_NORM, OP_SQUARE, OP_LVL_NEG, OP_LVL_MUL, OP_LVL_RND,
        OP_CRV_SET, OP_CRV_SQ, OP_DIV_STEP, OP_CRV_END,
        OP_SM_PREP, OP_SM_SEL, OP_SM_MUL, OP_SM_ADD, OP_GAIN,
        OP_EXP_MUL, OP_EXP_RND, OP_POW, OP_SCALE, OP_SHIFT, OP_SAT, OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] cnt;
        logic             zero_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic n_msb;
        logic knee_soft;
    } dp_status_t;

    // Horner constants of the 2^f polynomial, innermost first
    function automatic logic [16:0] pow_coef(input logic [1:0] k);
        case (k)
            2'd0:    pow_coef = 17'd14712;
            2'd1:    pow_coef = 17'd45618;
            default: pow_coef = 17'd65536;
        endcase
    endfunction

endpackage

// ----- design/alp_ctrl.sv -----
// Sequencer of the audio peak limiter: walks one sample through the datapath.
// Depends on alp_pkg; drives alp_dp through dp_cmd_t and reads dp_status_t.
`timescale 1ns / 1ps
module alp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 auto_mk,
    input  alp_pkg::dp_status_t  status,
    output alp_pkg::dp_cmd_t     cmd
);
    import alp_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pass_reg, pass_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pass_next    = pass_reg;
        cmd.op       = OP_NONE;
        cmd.cnt      = cnt_reg;
        cmd.zero_sel = pass_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = status.in_zero ? ST_DONE : ST_NORM;
                end
            end
            ST_NORM: begin
                cmd.op = OP_NORM;
                if (status.n_msb) begin
                    state_next = ST_SQUARE;
                    cnt_next   = '0;
                end
            end
            ST_SQUARE: begin
                cmd.op = OP_SQUARE;
                if (cnt_reg == CNT_W'(15)) begin
                    state_next = ST_LVL_NEG;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LVL_NEG: begin
                cmd.op     = OP_LVL_NEG;
                state_next = ST_LVL_MUL;
            end
            ST_LVL_MUL: begin
                cmd.op     = OP_LVL_MUL;
                state_next = ST_LVL_RND;
            end
            ST_LVL_RND: begin
                cmd.op     = OP_LVL_RND;
                state_next = ST_CRV_SET;
                pass_next  = 1'b0;
            end
            ST_CRV_SET: begin
                cmd.op     = OP_CRV_SET;
                state_next = ST_CRV_SQ;
            end
            ST_CRV_SQ: begin
                cmd.op     = OP_CRV_SQ;
                state_next = ST_CRV_DIV;
                cnt_next   = CNT_W'(13);
            end
            ST_CRV_DIV: begin
                if (!status.knee_soft) begin
                    state_next = ST_CRV_END;
                end else begin
                    cmd.op = OP_DIV_STEP;
                    if (cnt_reg == '0) begin
                        state_next = ST_CRV_END;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_CRV_END: begin
                cmd.op = OP_CRV_END;
                if (!pass_reg && auto_mk) begin
                    pass_next  = 1'b1;
                    state_next = ST_CRV_SET;
                end else begin
                    state_next = ST_SM_PREP;
                end
            end
            ST_SM_PREP: begin
                cmd.op     = OP_SM_PREP;
                state_next = ST_SM_SEL;
            end
            ST_SM_SEL: begin
                cmd.op     = OP_SM_SEL;
                state_next = ST_SM_MUL;
            end
            ST_SM_MUL: begin
                cmd.op     = OP_SM_MUL;
                state_next = ST_SM_ADD;
            end
            ST_SM_ADD: begin
                cmd.op     = OP_SM_ADD;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.op     = OP_GAIN;
                state_next = ST_EXP_MUL;
            end
            ST_EXP_MUL: begin
                cmd.op     = OP_EXP_MUL;
                state_next = ST_EXP_RND;
            end
            ST_EXP_RND: begin
                cmd.op     = OP_EXP_RND;
                state_next = ST_POW;
                cnt_next   = '0;
            end
            ST_POW: begin
                cmd.op = OP_POW;
                if (cnt_reg == CNT_W'(2)) begin
                    state_next = ST_SCALE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.op     = OP_SHIFT;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.op     = OP_SAT;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.op     = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !m_tready) || (cmd.op == OP_PUBLISH);
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- design/alp_dp.sv -----
// Datapath of the audio peak limiter: level, knee curve, smoothing, gain, scaling.
// Depends on alp_pkg; each operation is selected by the command from alp_ctrl.
`timescale 1ns / 1ps
module alp_dp #(
    parameter int SAMPLE_BITS = alp_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = alp_pkg::COEFF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  alp_pkg::cfg_t                 cfg,
    input  alp_pkg::dp_cmd_t              cmd,
    output alp_pkg::dp_status_t           status,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic signed [alp_pkg::GAIN_W-1:0] gain_db
);
    import alp_pkg::*;

    localparam int LZ_W    = $clog2(SAMPLE_BITS);
    localparam int NEG_W   = LZ_W + 16;
    localparam int LVL_W   = NEG_W + 19;
    localparam int P_W     = 17;
    localparam int MAG_W   = SAMPLE_BITS + P_W;
    localparam int SH_W    = MAG_W + 6;
    localparam int PROD_W  = 44;
    localparam int SUM_W   = ((PROD_W > 25 + COEFF_BITS) ? PROD_W : 25 + COEFF_BITS) + 1;
    localparam logic [31:0] ONE32 = 32'(1) << COEFF_BITS;

    logic [SAMPLE_BITS-1:0]          a_in, a_reg, n_reg;
    logic                            pos_reg;
    logic [LZ_W-1:0]                 lz_reg;
    logic [30:0]                     m_reg;
    logic [15:0]                     frac_reg;
    logic [NEG_W-1:0]                neg_reg;
    logic [LVL_W-1:0]                lvl_prod_reg;
    logic signed [16:0]              xdb_reg, crv_x_reg, crv_res_reg, cx_reg, c0_reg;
    logic                            knee_soft_reg;
    logic [14:0]                     d_reg;
    logic [30:0]                     rem_reg;
    logic [16:0]                     den_reg;
    logic [13:0]                     dq_reg;
    logic signed [24:0]              g256_reg;
    logic signed [25:0]              diff_reg;
    logic [16:0]                     c_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [SMOOTH_W-1:0]      sm_reg, sm_next;
    logic signed [GAIN_W-1:0]        gm8_reg;
    logic signed [38:0]              eprod_reg;
    logic signed [6:0]               ip_reg;
    logic [15:0]                     f_reg;
    logic [P_W-1:0]                  p_reg;
    logic [MAG_W-1:0]                mag_reg;
    logic [SH_W-1:0]                 shv_reg;
    logic signed [SAMPLE_BITS-1:0]   y_res_reg, out_y_reg;
    logic signed [GAIN_W-1:0]        out_g_reg;

    // combinational results of the individual operations
    logic [31:0]              n32;
    logic [61:0]              sq;
    logic [31:0]              sq_sh;
    logic [NEG_W-1:0]         neg_full, frac_ext;
    logic [LVL_W-1:0]         lvl_q;
    logic [15:0]              lvl_qc;
    logic signed [16:0]       crv_x, t17;
    logic signed [19:0]       x2, t20, w20, lo20, hi20, d20;
    logic                     hard;
    logic [30:0]              trial;
    logic signed [16:0]       crv_out;
    logic signed [16:0]       gc;
    logic [15:0]              coeff_sel;
    logic [16:0]              c_sel;
    logic signed [SUM_W-1:0]  sum, sum_fl;
    logic                     sum_inc;
    logic signed [17:0]       mk;
    logic signed [26:0]       gm16;
    logic signed [GAIN_W-1:0] gm8_sat;
    logic signed [38:0]       e16_full;
    logic [32:0]              pf;
    logic signed [7:0]        sh_amt;
    logic [5:0]               sh_r;
    logic [SH_W-1:0]          mag_ext, sh_tmp, sh_val;
    logic [SH_W-1:0]          lim, mag_sat;

    assign a_in = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;

    assign status.in_zero   = (sample_in == '0);
    assign status.n_msb     = n_reg[SAMPLE_BITS-1];
    assign status.knee_soft = knee_soft_reg;

    always_comb begin
        // mantissa aligned to Q1.30
        n32   = 32'(n_reg) << (32 - SAMPLE_BITS);
        sq    = 62'(m_reg) * 62'(m_reg);
        sq_sh = sq[61:30];

        neg_full = {lz_reg, 16'h0000};
        frac_ext = NEG_W'(frac_reg);

        lvl_q  = (lvl_prod_reg + (LVL_W'(1) << 23)) >> 24;
        lvl_qc = (lvl_q > LVL_W'(32768)) ? 16'd32768 : lvl_q[15:0];

        // static curve
        crv_x = cmd.zero_sel ? 17'sd0 : xdb_reg;
        t17   = 17'(cfg.threshold);
        t20   = 20'(cfg.threshold);
        w20   = $signed({6'b0, cfg.knee});
        x2    = 20'(crv_x) <<< 1;
        lo20  = (t20 <<< 1) - w20;
        hi20  = (t20 <<< 1) + w20;
        d20   = x2 - lo20;
        hard  = cfg.hard || (cfg.knee < KNEE_MIN);
        trial = 31'(den_reg) << cmd.cnt;
        crv_out = knee_soft_reg ? (crv_x_reg - $signed({3'b000, dq_reg})) : crv_res_reg;

        // smoothing
        gc        = cx_reg - xdb_reg;
        coeff_sel = (g256_reg <= 25'(sm_reg)) ? cfg.atk_coeff : cfg.rel_coeff;
        c_sel     = (32'(coeff_sel) > ONE32) ? 17'(ONE32) : 17'(coeff_sel);
        sum       = SUM_W'(prod_reg) + (SUM_W'(g256_reg) <<< COEFF_BITS);
        sum_fl    = sum >>> COEFF_BITS;
        sum_inc   = sum[SUM_W-1] && (|sum[COEFF_BITS-1:0]);
        sm_next   = SMOOTH_W'(sum_fl) + SMOOTH_W'(sum_inc);

        // makeup and rounding to Q8.8
        mk   = cfg.auto_mk ? (18'sd0 - 18'(c0_reg)) : 18'(cfg.makeup);
        gm16 = (27'(sm_reg) + (27'(mk) <<< 8) + 27'sd128) >>> 8;
        if (gm16 > 27'sd32767) begin
            gm8_sat = 16'sd32767;
        end else if (gm16 < -27'sd32768) begin
            gm8_sat = -16'sd32768;
        end else begin
            gm8_sat = gm16[15:0];
        end

        e16_full = (eprod_reg + 39'sd32768) >>> 16;
        pf       = 33'(p_reg) * 33'(f_reg);

        // scaling shift by ip - 16, rounding on the right
        sh_amt  = 8'(ip_reg) - 8'sd16;
        sh_r    = 6'(-sh_amt);
        mag_ext = SH_W'(mag_reg);
        sh_tmp  = mag_ext >> (sh_r - 6'd1);
        if (!sh_amt[7]) begin
            sh_val = mag_ext << sh_amt[2:0];
        end else begin
            sh_val = (sh_tmp + 1'b1) >> 1;
        end
        lim     = (SH_W'(1) << (SAMPLE_BITS - 1)) - SH_W'(pos_reg);
        mag_sat = (shv_reg > lim) ? lim : shv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_reg <= '0;
        end else if (cmd.op == OP_SM_ADD) begin
            sm_reg <= sm_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                a_reg     <= a_in;
                n_reg     <= a_in;
                lz_reg    <= '0;
                pos_reg   <= !sample_in[SAMPLE_BITS-1] && (sample_in != '0);
                y_res_reg <= '0;
                gm8_reg   <= '0;
            end
            OP_NORM: begin
                if (n_reg[SAMPLE_BITS-1]) begin
                    m_reg    <= n32[31:1];
                    frac_reg <= '0;
                end else begin
                    n_reg  <= n_reg << 1;
                    lz_reg <= lz_reg + 1'b1;
                end
            end
            OP_SQUARE: begin
                if (sq_sh[31]) begin
                    m_reg <= sq_sh[31:1];
                end else begin
                    m_reg <= sq_sh[30:0];
                end
                frac_reg <= {frac_reg[14:0], sq_sh[31]};
            end
            OP_LVL_NEG: begin
                neg_reg <= (neg_full >= frac_ext) ? (neg_full - frac_ext) : '0;
            end
            OP_LVL_MUL: begin
                lvl_prod_reg <= LVL_W'(neg_reg) * LVL_W'(DB_PER_OCT);
            end
            OP_LVL_RND: begin
                xdb_reg <= 17'sd0 - $signed({1'b0, lvl_qc});
            end
            OP_CRV_SET: begin
                crv_x_reg     <= crv_x;
                knee_soft_reg <= 1'b0;
                d_reg         <= d20[14:0];
                if (hard) begin
                    crv_res_reg <= (crv_x < t17) ? crv_x : t17;
                end else if (x2 < lo20) begin
                    crv_res_reg <= crv_x;
                end else if (x2 > hi20) begin
                    crv_res_reg <= t17;
                end else begin
                    crv_res_reg   <= crv_x;
                    knee_soft_reg <= 1'b1;
                end
            end
            OP_CRV_SQ: begin
                rem_reg <= 31'(30'(d_reg) * 30'(d_reg)) + 31'({cfg.knee, 2'b00});
                den_reg <= {cfg.knee, 3'b000};
                dq_reg  <= '0;
            end
            OP_DIV_STEP: begin
                if (rem_reg >= trial) begin
                    rem_reg         <= rem_reg - trial;
                    dq_reg[cmd.cnt] <= 1'b1;
                end
            end
            OP_CRV_END: begin
                if (cmd.zero_sel) begin
                    c0_reg <= crv_out;
                end else begin
                    cx_reg <= crv_out;
                end
            end
            OP_SM_PREP: begin
                g256_reg <= 25'(gc) <<< 8;
            end
            OP_SM_SEL: begin
                c_reg    <= c_sel;
                diff_reg <= 26'(sm_reg) - 26'(g256_reg);
            end
            OP_SM_MUL: begin
                prod_reg <= PROD_W'($signed({1'b0, c_reg})) * PROD_W'(diff_reg);
            end
            OP_GAIN: begin
                gm8_reg <= gm8_sat;
            end
            OP_EXP_MUL: begin
                eprod_reg <= 39'(gm8_reg) * 39'(LOG2_10_DIV20);
            end
            OP_EXP_RND: begin
                ip_reg <= e16_full[22:16];
                f_reg  <= e16_full[15:0];
                p_reg  <= POW_SEED;
            end
            OP_POW: begin
                p_reg <= pow_coef(cmd.cnt[1:0]) + pf[32:16];
            end
            OP_SCALE: begin
                mag_reg <= MAG_W'(a_reg) * MAG_W'(p_reg);
            end
            OP_SHIFT: begin
                shv_reg <= sh_val;
            end
            OP_SAT: begin
                y_res_reg <= pos_reg ? SAMPLE_BITS'(mag_sat) : SAMPLE_BITS'(-mag_sat);
            end
            OP_PUBLISH: begin
                out_y_reg <= y_res_reg;
                out_g_reg <= gm8_reg;
            end
            default: begin
            end
        endcase
    end

    assign sample_out = out_y_reg;
    assign gain_db    = out_g_reg;

endmodule

// ----- design/audio_peak_limiter_core.sv -----
// Top level of the audio peak limiter: ports, configuration registers, controller and datapath.
// Depends on alp_pkg, alp_ctrl and alp_dp.
`timescale 1ns / 1ps
// Feedforward peak limiter. Each sample on the s_ stream is measured in dB
// below full scale, clamped by a hard or quadratic soft-knee curve at the
// threshold, the gain reduction is smoothed (attack when falling, release when
// rising), makeup gain is added and the sample is scaled by 10^(gain/20) with
// saturation. One sample is processed at a time. The time from acceptance to
// a ready result of a nonzero sample depends on the number of leading zeros
// of its magnitude (one normalization shift per cycle) and on the knee curve
// evaluations, which run the knee divider when the level falls inside the
// soft knee (one quotient bit per cycle); the curve is evaluated twice in auto
// makeup mode. It is set by the normalization loop, the sixteen squaring
// steps of the log unit and the knee divider. A zero sample goes straight to
// the result stage and leaves the smoothing state untouched. The block is
// ready for the next sample in the cycle after a result is published. The
// result waits in an output register, so a new sample is taken while the
// previous result is still pending. Configuration writes are taken every
// cycle and must only be issued while the block is idle.
module audio_peak_limiter_core #(
    parameter int SAMPLE_BITS = alp_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = alp_pkg::COEFF_BITS_DEF,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + alp_pkg::GAIN_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave stream: sample_in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,   // sample_in
    // master stream: sample_out, gain_db
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_TDATA_W-1:0]            m_tdata,   // sample_out, gain_db
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [alp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [alp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import alp_pkg::*;

    cfg_t                          cfg_reg;
    dp_cmd_t                       cmd;
    dp_status_t                    status;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic signed [GAIN_W-1:0]      gain_db;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.knee      <= '0;
            cfg_reg.makeup    <= '0;
            cfg_reg.auto_mk   <= 1'b0;
            cfg_reg.hard      <= 1'b0;
            cfg_reg.atk_coeff <= '0;
            cfg_reg.rel_coeff <= RELEASE_RST;
        end else if (cfg_valid) begin
            // Drop writes to indexes beyond the register list.
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data;
                CFG_KNEE:      cfg_reg.knee      <= cfg_data[13:0];
                CFG_MAKEUP:    cfg_reg.makeup    <= cfg_data[13:0];
                CFG_AUTO:      cfg_reg.auto_mk   <= cfg_data[0];
                CFG_HARD:      cfg_reg.hard      <= cfg_data[0];
                CFG_ATTACK:    cfg_reg.atk_coeff <= cfg_data;
                CFG_RELEASE:   cfg_reg.rel_coeff <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: accepts a sample only when idle, holds the output handshake.
    alp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .auto_mk  (cfg_reg.auto_mk),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: holds the smoothing state and the output register.
    alp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .sample_out (sample_out),
        .gain_db    (gain_db)
    );

    // Pack the result: sample_out in the low bits, gain_db above, zero padding.
    assign m_tdata = M_TDATA_W'({gain_db, sample_out});

endmodule

// ----- design/alp_checker.sv -----
// Port-level checks for the audio peak limiter, bound to the top level.
// Depends on audio_peak_limiter_core for the bind target only.
`timescale 1ns / 1ps
module alp_checker #(
    parameter int M_W = 40
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [M_W-1:0] m_tdata
);

    // A stalled result stays offered.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result keeps its payload.
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // One sample at a time: no second transaction right after one is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // Reset empties the output and leaves the block ready for a sample.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind audio_peak_limiter_core alp_checker #(
    .M_W (M_TDATA_W)
) u_alp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/audio_peak_limiter_core_tb.sv -----
// Self-checking testbench for audio_peak_limiter_core: random and directed samples
// under several limiter settings, checked against an in-bench fixed-point predictor.
// Depends on alp_pkg and the design files of the block.
`timescale 1ns / 1ps
module audio_peak_limiter_core_tb;
    import alp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 600;

    typedef struct {
        logic [23:0] sample;
        logic [15:0] gain;
    } lim_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // sample_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // sample_out, gain_db
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Predictor copy of the registers and the smoothing state (Q8.16)
    int          thr_q88;
    int          knee_q88;
    int          mkup_q88;
    bit          auto_mk;
    bit          hard_kn;
    longint      atk_c;
    longint      rel_c;
    longint      gain_q816;

    logic [23:0]  sample_q[$];
    lim_result_t  result_q[$];
    int           fail_cnt = 0;
    int           in_cnt = 0;
    int           out_cnt = 0;
    int           idle_cnt = 0;
    bit           in_acc = 0;
    bit           no_idle = 0;
    bit           hold_arm = 0;
    bit           hold_done = 0;
    int           s_gap = 0;
    int           m_gap = 0;
    int           cfg_cnt = 0;

    audio_peak_limiter_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Level of a magnitude in Q8.8 dB below full scale
    function automatic int level_q88(longint unsigned a);
        int              e;
        longint unsigned m, negv, q;
        longint unsigned frac;
        e = 0;
        while (e < 40 && (a >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (a << (30 - e)) : (a >> (e - 30));
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        if (e > 23) e = 23;
        negv = longint'(23 - e) * 64'd65536;
        negv = (negv >= frac) ? negv - frac : 64'd0;
        q = (negv * 64'd394566 + (64'd1 << 23)) >> 24;
        if (q > 64'd32768) q = 64'd32768;
        return -int'(q);
    endfunction

    // Static limiter curve, hard or quadratic soft knee
    function automatic int knee_curve(int x);
        longint unsigned d, q;
        if (hard_kn || knee_q88 < 13) return (x < thr_q88) ? x : thr_q88;
        if (2 * x < 2 * thr_q88 - knee_q88) return x;
        if (2 * x > 2 * thr_q88 + knee_q88) return thr_q88;
        d = longint'(2 * x - 2 * thr_q88 + knee_q88);
        q = (d * d + 4 * longint'(knee_q88)) / (8 * longint'(knee_q88));
        return x - int'(q);
    endfunction

    function automatic longint unsigned exp2_frac(longint unsigned f);
        longint unsigned p;
        p = 5206;
        p = 14712 + ((p * f) >> 16);
        p = 45618 + ((p * f) >> 16);
        return 65536 + ((p * f) >> 16);
    endfunction

    // Compute the limited sample and gain, advance the smoothing state
    function automatic lim_result_t limit_sample(logic [23:0] raw);
        lim_result_t     r;
        longint          x, c, sum, gm16, gm8, e16, ip, f, sh;
        longint unsigned a, mag, lim;
        int              xdb, gc, mk;
        x = longint'(signed'(raw));
        if (x == 0) begin
            r.sample = '0;
            r.gain = '0;
            return r;
        end
        a = (x < 0) ? -x : x;
        xdb = level_q88(a);
        gc = knee_curve(xdb) - xdb;
        c = (longint'(gc) * 256 <= gain_q816) ? atk_c : rel_c;
        if (c > 65536) c = 65536;
        sum = c * gain_q816 + (65536 - c) * (longint'(gc) * 256);
        if (sum >= 0) gain_q816 = sum >>> 16;
        else gain_q816 = -((-sum) >>> 16);
        mk = auto_mk ? -knee_curve(0) : mkup_q88;
        gm16 = gain_q816 + longint'(mk) * 256;
        gm8 = (gm16 + 128) >>> 8;
        if (gm8 > 32767) gm8 = 32767;
        if (gm8 < -32768) gm8 = -32768;
        e16 = (gm8 * 2786635 + 32768) >>> 16;
        ip = e16 >>> 16;
        f = e16 - ip * 65536;
        mag = a * exp2_frac(f);
        sh = ip - 16;
        if (sh >= 0) mag = mag << sh;
        else mag = (mag + (64'd1 << (-sh - 1))) >> (-sh);
        lim = (64'd1 << 23) - ((x > 0) ? 1 : 0);
        if (mag > lim) mag = lim;
        r.sample = (x > 0) ? mag[23:0] : 24'(-mag);
        r.gain = gm8[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, out_cnt);
        fail_cnt++;
    endtask

    // Monitor: take input and output transactions at the rising edge
    always @(posedge aclk) begin
        lim_result_t want;
        in_acc = s_tvalid && s_tready && aresetn;
        if (in_acc) begin
            result_q.push_back(limit_sample(s_tdata));
            in_cnt++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[23:0], 24'h0);
            end else begin
                want = result_q.pop_front();
                if (m_tdata[23:0] !== want.sample)
                    report_mismatch("sample_out", m_tdata[23:0], want.sample);
                if (m_tdata[39:24] !== want.gain)
                    report_mismatch("gain_db", {8'h0, m_tdata[39:24]}, {8'h0, want.gain});
            end
            out_cnt++;
        end
        if (in_acc || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** audio_peak_limiter_core: FAILED **");
            $finish;
        end
    end

    // Driver: present the next pending sample, with random idle bursts
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_acc)) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap--;
            end else if (sample_q.size() > 0) begin
                s_tdata <= sample_q.pop_front();
                s_tvalid <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 17);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_arm && !hold_done) begin
                hold_done = 1;
                m_gap = LONG_HOLD;
            end
            if (m_gap > 0) begin
                m_tready <= 1'b0;
                m_gap--;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) m_gap = $urandom_range(1, 17);
            end
        end
    end

    task automatic cfg_write(cfg_reg_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: thr_q88 = int'(signed'(val));
            CFG_KNEE:      knee_q88 = int'(val[13:0]);
            CFG_MAKEUP:    mkup_q88 = int'(signed'(val[13:0]));
            CFG_AUTO:      auto_mk = val[0];
            CFG_HARD:      hard_kn = val[0];
            CFG_ATTACK:    atk_c = longint'(val);
            CFG_RELEASE:   rel_c = longint'(val);
            default: ;
        endcase
        cfg_cnt++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every expected result is back, then let the block settle
    task automatic drain();
        while (sample_q.size() > 0 || s_tvalid || result_q.size() > 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic apply_cfg(int thr, int knee, int mk, bit am, bit hk, int atk, int rel);
        drain();
        cfg_write(CFG_THRESHOLD, thr[15:0]);
        cfg_write(CFG_KNEE, knee[15:0]);
        cfg_write(CFG_MAKEUP, mk[15:0]);
        cfg_write(CFG_AUTO, {15'h0, am});
        cfg_write(CFG_HARD, {15'h0, hk});
        cfg_write(CFG_ATTACK, atk[15:0]);
        cfg_write(CFG_RELEASE, rel[15:0]);
    endtask

    function automatic logic [23:0] rand_sample();
        int v;
        case ($urandom_range(0, 11))
            0: return 24'h0;
            1: return 24'h800000;
            2: return 24'h7FFFFF;
            default: begin
                v = int'($urandom) >>> (8 + $urandom_range(0, 23));
                return v[23:0];
            end
        endcase
    endfunction

    task automatic random_batch(int n);
        repeat (n) sample_q.push_back(rand_sample());
        drain();
    endtask

    task automatic random_cfg();
        int knee;
        knee = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(13, 12288);
        apply_cfg(-$urandom_range(0, 32768), knee, $urandom_range(0, 8704) - 2560,
                  $urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom);
    endtask

    initial begin
        thr_q88 = -2560; knee_q88 = 0; mkup_q88 = 0; auto_mk = 0; hard_kn = 0;
        atk_c = 0; rel_c = 65520; gain_q816 = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes and zero under reset settings
        sample_q = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF,
                     24'h000000, 24'h400000, 24'hC00000, 24'h000100, 24'h7FFFFF};
        drain();
        // Soft knee, auto makeup, odd knee width at the field maximum
        apply_cfg(-2048, 16383, 0, 1, 0, 32768, 65535);
        sample_q = '{24'h7FFFFF, 24'h200000, 24'h100000, 24'h080000, 24'h000000,
                     24'h800001, 24'h000010};
        drain();
        // Tiny knee counts as hard, extreme threshold and makeup
        apply_cfg(-32768, 12, 6144, 0, 0, 0, 0);
        sample_q = '{24'h000001, 24'h7FFFFF, 24'h800000, 24'h000003};
        drain();
        apply_cfg(0, 12288, -2560, 0, 1, 65535, 65535);
        sample_q = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'h123456};
        drain();

        // Random phases; the long receiver hold-off fills the block during one
        random_cfg();
        hold_arm = 1;
        random_batch(120);
        repeat (4) begin
            random_cfg();
            random_batch(110);
        end
        apply_cfg(-256, 3072, 1024, 1, 0, 60000, 65000);
        no_idle = 1;
        random_batch(130);

        drain();
        $display("covered %0d samples, %0d results, %0d register writes over 10 settings",
                 in_cnt, out_cnt, cfg_cnt);
        if (fail_cnt == 0) begin
            $display("** audio_peak_limiter_core: PASSED **");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("** audio_peak_limiter_core: FAILED **");
        end
        $finish;
    end
endmodule
